>>> rtl/nlcf_pkg.sv
package nlcf_pkg;

    localparam int TAG_BITS = 32;

    localparam logic [3:0] CLS_OTHER   = 4'd0;
    localparam logic [3:0] CLS_NEWLINE = 4'd1;
    localparam logic [3:0] CLS_COMMA   = 4'd2;
    localparam logic [3:0] CLS_LPAREN  = 4'd3;
    localparam logic [3:0] CLS_RPAREN  = 4'd4;
    localparam logic [3:0] CLS_LBRACK  = 4'd5;
    localparam logic [3:0] CLS_RBRACK  = 4'd6;
    localparam logic [3:0] CLS_RBRACE  = 4'd7;
    localparam logic [3:0] CLS_ELSE    = 4'd8;
    localparam logic [3:0] CLS_CHAIN   = 4'd9;
    localparam logic [3:0] CLS_RANGE   = 4'd10;
    localparam logic [3:0] CLS_UNARY   = 4'd11;

    typedef struct packed {
        logic [3:0]          token_class;
        logic                is_operator;
        logic                begins_operand;
        logic                adjacent_to_previous;
        logic [TAG_BITS-1:0] token_tag;
        logic                end_of_stream;
    } t_in;

    typedef struct packed {
        logic [TAG_BITS-1:0] out_tag;
        logic [3:0]          out_class;
        logic                pending_overflow;
        logic                last_of_run;
    } t_out;

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

>>> rtl/newline_continuation_filter.sv
// Newline continuation filter.
// Input channel: one classified token per beat (i_in_valid / o_in_stall).
// Output channel: emitted tokens (o_out_valid / i_out_stall), one per beat.
// Newline tokens are written into a pending RAM and produce no beat until a
// non-newline token or end of stream decides the run. A dropped run, or no
// run, lets the token through: it is on the output register in the cycle
// after acceptance; tokens stream at one per cycle while not stalled.
// A kept run of N newlines is read out of the pending RAM one entry per
// cycle unless the receiver stalls; the input stalls during the drain: the
// first RAM read, the N newline beats, then the token (or the return
// to idle after an end of stream). Drain speed is set by the single RAM read port.
// End of stream flushes a kept run (last_of_run on its final newline) and
// clears depths, previous-token state and the pending count.
// When the receiver stalls, the output register holds its beat; newline
// tokens are still taken into the RAM, other tokens wait.
// Reset (i_rst_n low, synchronous) empties the run and the output register.
module newline_continuation_filter #(
    parameter int PENDING_DEPTH = 8,
    parameter int LEVEL_BITS    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  nlcf_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output nlcf_pkg::t_out o_out_data
);

    localparam int AW = PENDING_DEPTH > 1 ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(PENDING_DEPTH);
    localparam logic signed [LEVEL_BITS-1:0] LVL_MAX = {1'b0, {(LEVEL_BITS-1){1'b1}}};
    localparam logic signed [LEVEL_BITS-1:0] LVL_MIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};

    nlcf_pkg::t_state r_state, n_state;
    logic signed [LEVEL_BITS-1:0] r_paren, n_paren, r_brack, n_brack;
    logic                r_have_prev, n_have_prev;
    logic [3:0]          r_prev_cls, n_prev_cls;
    logic                r_prev_op, n_prev_op;
    logic                r_prev_dc, n_prev_dc;
    logic [CW-1:0]       r_pend_cnt, n_pend_cnt;
    logic                r_ovf, n_ovf;
    logic [CW-1:0]       r_drn_cnt, n_drn_cnt;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_rd_vld, n_rd_vld;
    logic                r_rd_last, n_rd_last;
    logic                r_hold_tok, n_hold_tok;
    nlcf_pkg::t_out      r_hold, n_hold;
    nlcf_pkg::t_out      r_out, n_out;
    logic                r_out_vld, n_out_vld;

    logic                          out_load;
    logic                          in_acc;
    logic                          nl_tok;
    logic                          has_next;
    logic                          cont;
    logic                          reads_rem;
    logic                          wr_en;
    logic                          rd_en;
    logic [nlcf_pkg::TAG_BITS-1:0] rd_data;

    nlcf_ram #(
        .WIDTH (nlcf_pkg::TAG_BITS),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pend_cnt[AW-1:0]),
        .i_wr_data (i_in_data.token_tag),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign out_load  = !r_out_vld || !i_out_stall;
    assign nl_tok    = (i_in_data.token_class == nlcf_pkg::CLS_NEWLINE) &&
                       !i_in_data.end_of_stream;
    assign o_in_stall = (r_state != nlcf_pkg::ST_RUN) || (!out_load && !nl_tok);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign has_next  = !i_in_data.end_of_stream;
    assign reads_rem = r_rd_idx != r_drn_cnt;

    always_comb begin
        cont = (r_paren > 0) || (r_brack > 0) ||
               (has_next && i_in_data.token_class == nlcf_pkg::CLS_CHAIN);
        if (r_have_prev) begin
            if (r_prev_cls == nlcf_pkg::CLS_COMMA) cont = 1'b1;
            if (r_prev_op && r_prev_cls == nlcf_pkg::CLS_RANGE &&
                has_next && i_in_data.begins_operand) cont = 1'b1;
            if (r_prev_op && r_prev_cls != nlcf_pkg::CLS_RANGE &&
                r_prev_cls != nlcf_pkg::CLS_UNARY) cont = 1'b1;
            if (r_prev_dc && has_next && i_in_data.begins_operand) cont = 1'b1;
            if (r_prev_cls == nlcf_pkg::CLS_RBRACE && has_next &&
                i_in_data.token_class == nlcf_pkg::CLS_ELSE) cont = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_paren     = r_paren;
        n_brack     = r_brack;
        n_have_prev = r_have_prev;
        n_prev_cls  = r_prev_cls;
        n_prev_op   = r_prev_op;
        n_prev_dc   = r_prev_dc;
        n_pend_cnt  = r_pend_cnt;
        n_ovf       = r_ovf;
        n_drn_cnt   = r_drn_cnt;
        n_rd_idx    = r_rd_idx;
        n_rd_vld    = r_rd_vld;
        n_rd_last   = r_rd_last;
        n_hold_tok  = r_hold_tok;
        n_hold      = r_hold;
        n_out       = r_out;
        n_out_vld   = r_out_vld && i_out_stall;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        unique case (r_state)
            nlcf_pkg::ST_DRAIN: begin
                if (out_load && r_rd_vld) begin
                    n_out.out_tag          = rd_data;
                    n_out.out_class        = nlcf_pkg::CLS_NEWLINE;
                    n_out.pending_overflow = r_hold.pending_overflow;
                    n_out.last_of_run      = r_rd_last && !r_hold_tok;
                    n_out_vld              = 1'b1;
                end else if (out_load && !reads_rem && r_hold_tok) begin
                    n_out     = r_hold;
                    n_out_vld = 1'b1;
                    n_state   = nlcf_pkg::ST_RUN;
                end
                if (!reads_rem && !r_rd_vld && !r_hold_tok) begin
                    n_state = nlcf_pkg::ST_RUN;
                end
                rd_en = reads_rem && (!r_rd_vld || out_load);
                if (rd_en) begin
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_rd_vld  = 1'b1;
                    n_rd_last = (r_rd_idx + CW'(1)) == r_drn_cnt;
                end else if (out_load) begin
                    n_rd_vld = 1'b0;
                end
            end
            nlcf_pkg::ST_RUN: begin
                if (in_acc) begin
                    if (i_in_data.end_of_stream) begin
                        if (r_pend_cnt != '0 && !cont) begin
                            n_state    = nlcf_pkg::ST_DRAIN;
                            n_hold_tok = 1'b0;
                            n_hold.pending_overflow = r_ovf;
                            n_drn_cnt  = r_pend_cnt;
                            n_rd_idx   = '0;
                        end
                        n_paren     = '0;
                        n_brack     = '0;
                        n_have_prev = 1'b0;
                        n_prev_cls  = nlcf_pkg::CLS_OTHER;
                        n_prev_op   = 1'b0;
                        n_prev_dc   = 1'b0;
                        n_pend_cnt  = '0;
                        n_ovf       = 1'b0;
                    end else if (nl_tok) begin
                        if (r_pend_cnt != CNT_FULL) begin
                            wr_en      = 1'b1;
                            n_pend_cnt = r_pend_cnt + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_hold.out_tag          = i_in_data.token_tag;
                        n_hold.out_class        = i_in_data.token_class;
                        n_hold.pending_overflow = r_ovf;
                        n_hold.last_of_run      = 1'b1;
                        if (r_pend_cnt != '0 && !cont) begin
                            n_state    = nlcf_pkg::ST_DRAIN;
                            n_hold_tok = 1'b1;
                            n_drn_cnt  = r_pend_cnt;
                            n_rd_idx   = '0;
                        end else begin
                            n_out.out_tag          = i_in_data.token_tag;
                            n_out.out_class        = i_in_data.token_class;
                            n_out.pending_overflow = r_ovf;
                            n_out.last_of_run      = 1'b1;
                            n_out_vld              = 1'b1;
                        end
                        n_pend_cnt = '0;
                        n_ovf      = 1'b0;
                        if (i_in_data.token_class == nlcf_pkg::CLS_LPAREN &&
                            r_paren != LVL_MAX) begin
                            n_paren = r_paren + LEVEL_BITS'(1);
                        end
                        if (i_in_data.token_class == nlcf_pkg::CLS_RPAREN &&
                            r_paren != LVL_MIN) begin
                            n_paren = r_paren - LEVEL_BITS'(1);
                        end
                        if (i_in_data.token_class == nlcf_pkg::CLS_LBRACK &&
                            r_brack != LVL_MAX) begin
                            n_brack = r_brack + LEVEL_BITS'(1);
                        end
                        if (i_in_data.token_class == nlcf_pkg::CLS_RBRACK &&
                            r_brack != LVL_MIN) begin
                            n_brack = r_brack - LEVEL_BITS'(1);
                        end
                        n_prev_dc = (i_in_data.token_class == nlcf_pkg::CLS_RBRACK) &&
                                    r_have_prev &&
                                    (r_prev_cls == nlcf_pkg::CLS_RBRACK) &&
                                    i_in_data.adjacent_to_previous;
                        n_have_prev = 1'b1;
                        n_prev_cls  = i_in_data.token_class;
                        n_prev_op   = i_in_data.is_operator;
                    end
                end
            end
            default: begin
                n_state = nlcf_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nlcf_pkg::ST_RUN;
            r_paren     <= '0;
            r_brack     <= '0;
            r_have_prev <= 1'b0;
            r_prev_cls  <= nlcf_pkg::CLS_OTHER;
            r_prev_op   <= 1'b0;
            r_prev_dc   <= 1'b0;
            r_pend_cnt  <= '0;
            r_ovf       <= 1'b0;
            r_drn_cnt   <= '0;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_hold_tok  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_paren     <= n_paren;
            r_brack     <= n_brack;
            r_have_prev <= n_have_prev;
            r_prev_cls  <= n_prev_cls;
            r_prev_op   <= n_prev_op;
            r_prev_dc   <= n_prev_dc;
            r_pend_cnt  <= n_pend_cnt;
            r_ovf       <= n_ovf;
            r_drn_cnt   <= n_drn_cnt;
            r_rd_idx    <= n_rd_idx;
            r_rd_vld    <= n_rd_vld;
            r_rd_last   <= n_rd_last;
            r_hold_tok  <= n_hold_tok;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> rtl/nlcf_ram.sv
module nlcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
